@@ sv/lmbs_pkg.sv @@
// Shared types, constants and helpers of the LED matrix bit-plane scanner.
package lmbs_pkg;

   localparam int PLANES = 3;
   localparam int ROWS = 7;
   localparam int STORE_ROWS = PLANES * ROWS;
   localparam int ADDR_W = $clog2(STORE_ROWS);

   localparam int PLANE_W = 2;
   localparam int ROW_W = 3;
   localparam int BYTE_W = 8;
   localparam int TICKS_W = 9;
   localparam int COUNT_W = 8;
   localparam int CSR_INDEX_W = 2;

   localparam logic [COUNT_W-1:0] COUNTER_RESET = 8'd235;
   localparam logic [TICKS_W-1:0] PLANE0_TICKS_RESET = 9'd2;
   localparam logic [TICKS_W-1:0] PLANE1_TICKS_RESET = 9'd8;
   localparam logic [TICKS_W-1:0] PLANE2_TICKS_RESET = 9'd20;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic BYTE_LOW = 1'b0;
   localparam logic BYTE_HIGH = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE0_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE1_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE2_TICKS = 2'd2;

   typedef struct packed {
      logic                command;
      logic [PLANE_W-1:0]  plane_index;
      logic [ROW_W-1:0]    row_index;
      logic                byte_index;
      logic [BYTE_W-1:0]   write_data;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]          row_select;
      logic [15:0]         column_word;
      logic [PLANE_W-1:0]  shown_plane;
      logic [ROW_W-1:0]    shown_row;
   } rsp_payload_type;

   typedef struct packed {
      logic                hit;
      logic [PLANE_W-1:0]  plane;
      logic [ROW_W-1:0]    row;
   } scan_type;

   typedef struct packed {
      logic                en;
      logic [PLANE_W-1:0]  plane;
      logic [ROW_W-1:0]    row;
      logic                byte_sel;
      logic [BYTE_W-1:0]   data;
   } store_write_type;

   function automatic logic [COUNT_W-1:0] reload_value(input logic [TICKS_W-1:0] ticks);
      logic [COUNT_W:0] diff;
      diff = 9'h100 - {1'b0, ticks[COUNT_W-1:0]};
      return diff[COUNT_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(input logic [PLANE_W-1:0] plane,
                                                    input logic [ROW_W-1:0] row);
      return ADDR_W'(plane) * ADDR_W'(ROWS) + ADDR_W'(row);
   endfunction

   function automatic logic [7:0] row_mask(input logic [ROW_W-1:0] row);
      logic [8:0] wide;
      wide = 9'd1 << (4'(row) + 4'd1);
      return wide[7:0];
   endfunction

endpackage

@@ sv/led_matrix_bitplane_scanner_core.sv @@
// LED matrix bit-plane scanner: top level with read stage and result register.
//
// Requests arrive on req_valid/req_stall with req_payload. A request with
// command tick advances the 8-bit tick counter; when the counter overflows it
// is reloaded from the current plane's tick register and one result carries
// the row mask, the row's 16-bit column word, plane and row. A request with
// command write loads one column byte of the frame store and gives no result.
// csr_valid/csr_ready write the three plane tick registers; csr_ready is
// always high and indexes beyond the list are dropped.
// A request is taken in every cycle in which req_stall is low. A tick request's
// result passes the frame store's registered read, then the result register,
// before it shows on rsp_valid. req_stall rises only while a read result sits
// in the read stage and the result register is held by rsp_stall, so up to two
// results queue behind a stalled receiver before requests stall.
// Synchronous reset clears the frame store's valid bits (it reads as zero),
// restores the tick registers, loads the tick counter with 235 and starts at
// plane 0, row 0; the first result comes after 21 ticks.
module led_matrix_bitplane_scanner_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lmbs_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lmbs_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lmbs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lmbs_pkg::TICKS_W-1:0]     csr_data
);
   import lmbs_pkg::*;

   logic               accept;
   logic               tick;
   scan_type           scan;
   store_write_type    store_wr;
   logic [15:0]        column_word;
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [PLANE_W-1:0] s1_plane_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic               s1_move;
   logic               out_load;
   logic               out_valid_ff;
   logic               out_valid_in;
   rsp_payload_type    out_ff;

   assign s1_move   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;
   assign tick      = accept && (req_payload.command == CMD_TICK);
   assign csr_ready = 1'b1;

   assign store_wr.en       = accept && (req_payload.command == CMD_WRITE);
   assign store_wr.plane    = req_payload.plane_index;
   assign store_wr.row      = req_payload.row_index;
   assign store_wr.byte_sel = req_payload.byte_index;
   assign store_wr.data     = req_payload.write_data;

   lmbs_timing u_timing (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .tick      (tick),
      .scan      (scan)
   );

   lmbs_frame_store u_frame_store (
      .clock       (clock),
      .reset       (reset),
      .wr          (store_wr),
      .rd          (scan),
      .column_word (column_word)
   );

   assign out_load     = s1_valid_ff && s1_move;
   assign s1_valid_in  = scan.hit || (s1_valid_ff && !s1_move);
   assign out_valid_in = out_load || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan.hit) begin
         s1_plane_ff <= scan.plane;
         s1_row_ff   <= scan.row;
      end
      if (out_load) begin
         out_ff.row_select  <= row_mask(s1_row_ff);
         out_ff.column_word <= column_word;
         out_ff.shown_plane <= s1_plane_ff;
         out_ff.shown_row   <= s1_row_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

@@ sv/lmbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lmbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/lmbs_frame_store.sv @@
// Frame store: low and high column byte RAMs with per-entry valid bits.
module lmbs_frame_store (
   input  logic                      clock,
   input  logic                      reset,
   input  lmbs_pkg::store_write_type wr,
   input  lmbs_pkg::scan_type        rd,
   output logic [15:0]               column_word
);
   import lmbs_pkg::*;

   logic                  wr_ok;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  lo_wr_en;
   logic                  hi_wr_en;
   logic [BYTE_W-1:0]     lo_q;
   logic [BYTE_W-1:0]     hi_q;
   logic [STORE_ROWS-1:0] lo_valid_ff;
   logic [STORE_ROWS-1:0] lo_valid_in;
   logic [STORE_ROWS-1:0] hi_valid_ff;
   logic [STORE_ROWS-1:0] hi_valid_in;
   logic                  lo_ok_ff;
   logic                  lo_ok_in;
   logic                  hi_ok_ff;
   logic                  hi_ok_in;

   assign wr_ok = wr.en && (wr.plane < PLANE_W'(PLANES)) && (wr.row < ROW_W'(ROWS));
   assign wr_addr = store_addr(wr.plane, wr.row);
   assign rd_addr = store_addr(rd.plane, rd.row);
   assign lo_wr_en = wr_ok && (wr.byte_sel == BYTE_LOW);
   assign hi_wr_en = wr_ok && (wr.byte_sel == BYTE_HIGH);

   lmbs_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_ROWS)) u_lo_ram (
      .clock   (clock),
      .wr_en   (lo_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr.data),
      .rd_en   (rd.hit),
      .rd_addr (rd_addr),
      .rd_data (lo_q)
   );

   lmbs_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_ROWS)) u_hi_ram (
      .clock   (clock),
      .wr_en   (hi_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr.data),
      .rd_en   (rd.hit),
      .rd_addr (rd_addr),
      .rd_data (hi_q)
   );

   always_comb begin
      lo_valid_in = lo_valid_ff;
      hi_valid_in = hi_valid_ff;
      if (lo_wr_en) begin
         lo_valid_in[wr_addr] = 1'b1;
      end
      if (hi_wr_en) begin
         hi_valid_in[wr_addr] = 1'b1;
      end
   end

   assign lo_ok_in = rd.hit ? lo_valid_ff[rd_addr] : lo_ok_ff;
   assign hi_ok_in = rd.hit ? hi_valid_ff[rd_addr] : hi_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_valid_ff <= '0;
         hi_valid_ff <= '0;
         lo_ok_ff    <= 1'b0;
         hi_ok_ff    <= 1'b0;
      end else begin
         lo_valid_ff <= lo_valid_in;
         hi_valid_ff <= hi_valid_in;
         lo_ok_ff    <= lo_ok_in;
         hi_ok_ff    <= hi_ok_in;
      end
   end

   assign column_word = {hi_ok_ff ? hi_q : '0, lo_ok_ff ? lo_q : '0};

endmodule

@@ sv/lmbs_timing.sv @@
// Tick registers, tick counter and row/plane scan counters.
module lmbs_timing (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [lmbs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lmbs_pkg::TICKS_W-1:0]       csr_data,
   input  logic                               tick,
   output lmbs_pkg::scan_type                 scan
);
   import lmbs_pkg::*;

   logic [TICKS_W-1:0] ticks0_ff;
   logic [TICKS_W-1:0] ticks0_in;
   logic [TICKS_W-1:0] ticks1_ff;
   logic [TICKS_W-1:0] ticks1_in;
   logic [TICKS_W-1:0] ticks2_ff;
   logic [TICKS_W-1:0] ticks2_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] count_inc;
   logic [PLANE_W-1:0] plane_ff;
   logic [PLANE_W-1:0] plane_in;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;
   logic [TICKS_W-1:0] cur_ticks;
   logic               overflow;

   always_comb begin
      ticks0_in = ticks0_ff;
      ticks1_in = ticks1_ff;
      ticks2_in = ticks2_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PLANE0_TICKS: ticks0_in = csr_data;
            CSR_PLANE1_TICKS: ticks1_in = csr_data;
            CSR_PLANE2_TICKS: ticks2_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (plane_ff)
         2'd0:    cur_ticks = ticks0_ff;
         2'd1:    cur_ticks = ticks1_ff;
         default: cur_ticks = ticks2_ff;
      endcase
   end

   assign count_inc = count_ff + 1'b1;
   assign overflow = tick && (count_inc == '0);

   always_comb begin
      count_in = count_ff;
      plane_in = plane_ff;
      row_in   = row_ff;
      if (overflow) begin
         count_in = reload_value(cur_ticks);
         if (row_ff == ROW_W'(ROWS - 1)) begin
            row_in   = '0;
            plane_in = (plane_ff == PLANE_W'(PLANES - 1)) ? '0 : plane_ff + 1'b1;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end else if (tick) begin
         count_in = count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks0_ff <= PLANE0_TICKS_RESET;
         ticks1_ff <= PLANE1_TICKS_RESET;
         ticks2_ff <= PLANE2_TICKS_RESET;
         count_ff  <= COUNTER_RESET;
         plane_ff  <= '0;
         row_ff    <= '0;
      end else begin
         ticks0_ff <= ticks0_in;
         ticks1_ff <= ticks1_in;
         ticks2_ff <= ticks2_in;
         count_ff  <= count_in;
         plane_ff  <= plane_in;
         row_ff    <= row_in;
      end
   end

   assign scan.hit   = overflow;
   assign scan.plane = plane_ff;
   assign scan.row   = row_ff;

endmodule

@@ sv/lmbs_checker.sv @@
// Port-level checks for the scanner core and their bind to the top level.
module lmbs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input lmbs_pkg::rsp_payload_type        rsp_payload
);
   import lmbs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   a_row_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_payload.row_select) && !rsp_payload.row_select[0]
         && rsp_payload.row_select[rsp_payload.shown_row + 3'd1]
         && (rsp_payload.shown_row < ROW_W'(ROWS))
         && (rsp_payload.shown_plane < PLANE_W'(PLANES)))
      else $error("row mask does not match shown row");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with the result side free");

endmodule

bind led_matrix_bitplane_scanner_core lmbs_checker u_lmbs_checker (.*);

@@ bench/led_matrix_bitplane_scanner_core_tb.sv @@
// Self-checking bench for the LED matrix bit-plane scanner core, with its own scan predictor.
module led_matrix_bitplane_scanner_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lmbs_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int DRAIN_LIMIT = 100000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int REPORT_CAP = 40;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TICKS_W-1:0] csr_data = '0;

   led_matrix_bitplane_scanner_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // predicted scanner state
   logic [BYTE_W-1:0] frame_bytes [PLANES][ROWS][2];
   logic [COUNT_W-1:0] tick_count;
   logic [PLANE_W-1:0] cur_plane;
   logic [ROW_W-1:0] cur_row;
   logic [TICKS_W-1:0] plane_ticks [PLANES];

   req_payload_type request_queue [$];
   rsp_payload_type rows_due [$];

   bit req_fire = 1'b0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   bit pressure_go = 1'b0;
   bit pressure_done = 1'b0;
   int hold_left = 0;

   int error_count = 0;
   int ticks_taken = 0;
   int writes_taken = 0;
   int rows_checked = 0;
   int stall_cycles = 0;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic void advance_scanner(input req_payload_type item);
      rsp_payload_type shown;
      int sel;
      if (item.command == CMD_WRITE) begin
         writes_taken++;
         if (item.plane_index < PLANES && item.row_index < ROWS)
            frame_bytes[item.plane_index][item.row_index][item.byte_index] = item.write_data;
         return;
      end
      ticks_taken++;
      tick_count = tick_count + 8'd1;
      if (tick_count != 8'd0)
         return;
      sel = (cur_plane < PLANES) ? cur_plane : PLANES - 1;
      tick_count = 8'd0 - plane_ticks[sel][COUNT_W-1:0];
      shown.row_select = 8'(9'd1 << (cur_row + 4'd1));
      shown.column_word = {frame_bytes[cur_plane][cur_row][BYTE_HIGH],
                           frame_bytes[cur_plane][cur_row][BYTE_LOW]};
      shown.shown_plane = cur_plane;
      shown.shown_row = cur_row;
      rows_due.push_back(shown);
      if (cur_row == ROWS - 1) begin
         cur_row = '0;
         cur_plane = (cur_plane == PLANES - 1) ? '0 : cur_plane + 1'b1;
      end else begin
         cur_row = cur_row + 1'b1;
      end
   endfunction

   function automatic void report_field(input string field, input int want, input int got);
      error_count++;
      if (error_count <= REPORT_CAP)
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
   endfunction

   function automatic req_payload_type frame_write(input logic [PLANE_W-1:0] plane,
                                                   input logic [ROW_W-1:0] row,
                                                   input logic byte_sel,
                                                   input logic [BYTE_W-1:0] data);
      req_payload_type item;
      item.command = CMD_WRITE;
      item.plane_index = plane;
      item.row_index = row;
      item.byte_index = byte_sel;
      item.write_data = data;
      return item;
   endfunction

   function automatic req_payload_type timer_tick();
      req_payload_type item;
      item = req_payload_type'($bits(req_payload_type)'($urandom));
      item.command = CMD_TICK;
      return item;
   endfunction

   // sample requests and results
   always @(posedge clock) begin : scan_monitor
      rsp_payload_type want;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && req_stall)
         stall_cycles++;
      if (!reset && req_valid && !req_stall)
         advance_scanner(req_payload);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rows_due.size() == 0) begin
            report_field("unexpected result", 0, rsp_payload);
         end else begin
            want = rows_due.pop_front();
            rows_checked++;
            if (rsp_payload.row_select !== want.row_select)
               report_field("row_select", want.row_select, rsp_payload.row_select);
            if (rsp_payload.column_word !== want.column_word)
               report_field("column_word", want.column_word, rsp_payload.column_word);
            if (rsp_payload.shown_plane !== want.shown_plane)
               report_field("shown_plane", want.shown_plane, rsp_payload.shown_plane);
            if (rsp_payload.shown_row !== want.shown_row)
               report_field("shown_row", want.shown_row, rsp_payload.shown_row);
         end
      end
   end

   // offer requests; hold the payload until taken
   always @(negedge clock) begin : request_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (request_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= request_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : result_receiver
      if (pressure_go && !pressure_done) begin
         hold_left = HOLD_OFF_CYCLES;
         pressure_done = 1'b1;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   task automatic write_ticks(input logic [CSR_INDEX_W-1:0] index,
                              input logic [TICKS_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (index != CSR_UNMAPPED)
         plane_ticks[index] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      while ((request_queue.size() != 0 || req_valid || rows_due.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int send_pct, input int recv_pct,
                            input int write_pct, input bit hold_receiver);
      logic [PLANE_W-1:0] plane;
      logic [ROW_W-1:0] row;
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      repeat (count) begin
         if ($urandom_range(0, 99) < write_pct) begin
            plane = PLANE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                                         : $urandom_range(0, PLANES - 1));
            row = ROW_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                     : $urandom_range(0, ROWS - 1));
            request_queue.push_back(frame_write(plane, row, 1'($urandom_range(0, 1)),
                                                BYTE_W'($urandom)));
         end else begin
            request_queue.push_back(timer_tick());
         end
      end
      if (hold_receiver) begin
         @(posedge clock);
         pressure_go = 1'b1;
      end
      wait_drained();
   endtask

   initial begin : stimulus
      foreach (frame_bytes[p, r, b])
         frame_bytes[p][r][b] = '0;
      tick_count = COUNTER_RESET;
      cur_plane = '0;
      cur_row = '0;
      plane_ticks[0] = PLANE0_TICKS_RESET;
      plane_ticks[1] = PLANE1_TICKS_RESET;
      plane_ticks[2] = PLANE2_TICKS_RESET;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 6;
      receiver_idle_pct = 49;
      request_queue.push_back(frame_write(2'd0, 3'd0, BYTE_HIGH, 8'hFF));
      request_queue.push_back(frame_write(2'd0, 3'd0, BYTE_LOW, 8'h81));
      request_queue.push_back(frame_write(PLANE_W'(PLANES - 1), ROW_W'(ROWS - 1),
                                          BYTE_HIGH, 8'hA5));
      request_queue.push_back(frame_write(PLANE_W'(PLANES - 1), ROW_W'(ROWS - 1),
                                          BYTE_LOW, 8'h5A));
      request_queue.push_back(frame_write(2'd3, 3'd2, BYTE_LOW, 8'hFF));
      request_queue.push_back(frame_write(2'd1, 3'd7, BYTE_HIGH, 8'hFF));
      repeat (21) request_queue.push_back(timer_tick());
      wait_drained();

      write_ticks(CSR_PLANE0_TICKS, 9'd1);
      write_ticks(CSR_PLANE1_TICKS, 9'd2);
      write_ticks(CSR_PLANE2_TICKS, 9'd4);
      run_phase(500, 6, 49, 25, 1'b0);

      write_ticks(CSR_PLANE0_TICKS, 9'd0);
      write_ticks(CSR_PLANE1_TICKS, 9'd256);
      write_ticks(CSR_PLANE2_TICKS, 9'd511);
      run_phase(300, 6, 49, 10, 1'b0);

      write_ticks(CSR_PLANE0_TICKS, 9'd257);
      write_ticks(CSR_PLANE1_TICKS, 9'd3);
      write_ticks(CSR_PLANE2_TICKS, 9'd5);
      run_phase(500, 49, 6, 25, 1'b0);

      write_ticks(CSR_UNMAPPED, 9'd1);
      write_ticks(CSR_PLANE0_TICKS, 9'd1);
      write_ticks(CSR_PLANE1_TICKS, 9'd1);
      write_ticks(CSR_PLANE2_TICKS, 9'd2);
      run_phase(300, 0, 0, 10, 1'b1);

      write_ticks(CSR_PLANE0_TICKS, PLANE0_TICKS_RESET);
      write_ticks(CSR_PLANE1_TICKS, PLANE1_TICKS_RESET);
      write_ticks(CSR_PLANE2_TICKS, PLANE2_TICKS_RESET);
      run_phase(350, 0, 0, 25, 1'b0);

      while (rows_due.size() != 0)
         report_field("missing result", rows_due.pop_front(), 0);

      $display("Scan run: %0d tick and %0d frame-write requests, %0d row results checked.",
               ticks_taken, writes_taken, rows_checked);
      $display("Tick settings from 1 to 256 and out of range; input stalled on %0d cycles.",
               stall_cycles);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
